FILE: sv/siut_pkg.sv
// Package for the sorted interval union table.
// Holds defaults, the controller state enum and command/status structs.
package siut_pkg;
  localparam int unsigned MaxIntervals = 16;
  localparam int unsigned CoordWidth   = 32;
  localparam int unsigned FieldWidth   = 32;
  localparam int unsigned IndexWidth   = 4;
  localparam int unsigned TotalWidth   = 5;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;      // capture input item
    logic scan_step; // process one slot during scan
    logic commit;    // write back
    logic rd_issue;  // issue read
    logic finish;    // form result
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } status_t;
endpackage

FILE: sv/siut_datapath.sv
// Datapath of the sorted interval union table: table memory, scan, rebuild.
// Depends on siut_pkg.
module siut_datapath #(
  parameter int unsigned MAX_INTERVALS = siut_pkg::MaxIntervals,
  parameter int unsigned COORD_WIDTH   = siut_pkg::CoordWidth,
  localparam int unsigned AW = $clog2(MAX_INTERVALS),
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  siut_pkg::cmd_t                    cmd_i,
  output siut_pkg::status_t                 status_o,
  input  logic                              kind_i,
  input  logic [siut_pkg::FieldWidth-1:0]   bound_a_i,
  input  logic [siut_pkg::FieldWidth-1:0]   bound_b_i,
  input  logic [siut_pkg::IndexWidth-1:0]   index_i,
  output logic [siut_pkg::FieldWidth-1:0]   entry_low_o,
  output logic [siut_pkg::FieldWidth-1:0]   entry_high_o,
  output logic                              entry_valid_o,
  output logic [siut_pkg::TotalWidth-1:0]   interval_total_o,
  output logic [siut_pkg::FieldWidth-1:0]   span_min_o,
  output logic [siut_pkg::FieldWidth-1:0]   span_max_o,
  output logic                              overflow_o
);
  localparam int unsigned W = (COORD_WIDTH < siut_pkg::FieldWidth) ? COORD_WIDTH
                                                                   : siut_pkg::FieldWidth;
  localparam int unsigned FW = siut_pkg::FieldWidth;

  localparam logic [1:0] PH_BEFORE = 2'd0;
  localparam logic [1:0] PH_MERGE  = 2'd1;
  localparam logic [1:0] PH_PLACED = 2'd2;

  // Two banks: scan reads old bank, writes compacted copy to the other.
  logic [2*W-1:0] mem_a [MAX_INTERVALS];
  logic [2*W-1:0] mem_b [MAX_INTERVALS];
  logic           bank_q;

  logic           kind_q;
  logic [siut_pkg::IndexWidth-1:0] idx_q;
  logic signed [W-1:0] lo_q, hi_q;
  logic [CW-1:0]  cnt_q;
  logic signed [W-1:0] smin_q, smax_q;
  logic [CW-1:0]  rp_q, wp_q;        // scan read and write pointers
  logic           scan_live_q;       // rword_q holds slot rp_q-1
  logic [1:0]     phase_q;           // 0 before, 1 merging, 2 placed
  logic           merged_q;          // new interval joined a stored one
  logic signed [W-1:0] mlo_q, mhi_q; // merged interval
  logic [2*W-1:0] rword_q;
  logic [2*W-1:0] rd_q;
  logic           ovf_q;

  logic signed [W-1:0] a_c, b_c, s_lo, s_hi;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  rd_addr;
  logic           consume;
  logic           advance;
  logic           wr_en;
  logic [2*W-1:0] wdata;
  logic [CW-1:0]  wp_d;
  logic [1:0]     phase_d;
  logic signed [W-1:0] mlo_d, mhi_d;
  logic           full_drop;
  logic           wr_fin;
  logic [2*W-1:0] fin_word;
  logic           do_wr;
  logic [2*W-1:0] wr_word;
  logic           rd_valid;

  assign a_c = signed'(bound_a_i[W-1:0]);
  assign b_c = signed'(bound_b_i[W-1:0]);

  assign raddr   = rp_q[AW-1:0];
  assign rd_addr = AW'(idx_q);
  assign s_lo = signed'(rword_q[2*W-1:W]);
  assign s_hi = signed'(rword_q[W-1:0]);

  // Decide on the slot in rword_q. A slot that must follow a freshly written
  // interval is not consumed: hold it and copy it in the next cycle.
  always_comb begin
    consume = 1'b1; wr_en = 1'b0; wdata = rword_q;
    wp_d = wp_q; phase_d = phase_q; mlo_d = mlo_q; mhi_d = mhi_q;
    if (scan_live_q) begin
      case (phase_q)
        PH_BEFORE: begin
          if (s_hi < lo_q) begin
            wr_en = 1'b1;
          end else if (s_lo <= hi_q) begin
            phase_d = PH_MERGE;
            mlo_d = (s_lo < lo_q) ? s_lo : lo_q;
            mhi_d = (s_hi > hi_q) ? s_hi : hi_q;
          end else begin
            // insert new interval, then this one
            phase_d = PH_PLACED; consume = 1'b0;
            wr_en = 1'b1; wdata = {lo_q, hi_q};
          end
        end
        PH_MERGE: begin
          if (s_lo <= hi_q) begin
            mhi_d = (s_hi > mhi_q) ? s_hi : mhi_q;
          end else begin
            phase_d = PH_PLACED; consume = 1'b0;
            wr_en = 1'b1; wdata = {mlo_q, mhi_q};
          end
        end
        PH_PLACED: begin
          wr_en = 1'b1;
        end
        default: ;
      endcase
      if (wr_en) wp_d = wp_q + 1'b1;
    end
  end

  assign advance = !scan_live_q || consume;
  assign status_o.scan_done = (rp_q == cnt_q) && advance;

  // An add that joins nothing while the table is full is dropped.
  assign full_drop = !merged_q && (cnt_q == CW'(MAX_INTERVALS));

  always_comb begin
    wr_fin = 1'b0; fin_word = {lo_q, hi_q};
    if (cmd_i.commit) begin
      if (phase_q == PH_MERGE) begin
        wr_fin = 1'b1; fin_word = {mlo_q, mhi_q};
      end else if (phase_q == PH_BEFORE && !full_drop) begin
        wr_fin = 1'b1; fin_word = {lo_q, hi_q};
      end
    end
  end

  assign do_wr   = (cmd_i.scan_step && wr_en) || wr_fin;
  assign wr_word = wr_fin ? fin_word : wdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && advance) begin
      if (bank_q) rword_q <= mem_b[raddr];
      else        rword_q <= mem_a[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      if (bank_q) mem_a[wp_q[AW-1:0]] <= wr_word;
      else        mem_b[wp_q[AW-1:0]] <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0; cnt_q <= '0; smin_q <= '0; smax_q <= '0;
      rp_q <= '0; wp_q <= '0; phase_q <= PH_BEFORE; scan_live_q <= 1'b0;
      merged_q <= 1'b0; mlo_q <= '0; mhi_q <= '0; ovf_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rp_q <= '0; wp_q <= '0; phase_q <= PH_BEFORE; scan_live_q <= 1'b0;
        merged_q <= 1'b0; ovf_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        wp_q <= wp_d; phase_q <= phase_d; mlo_q <= mlo_d; mhi_q <= mhi_d;
        if (phase_d == PH_MERGE) merged_q <= 1'b1;
        if (advance) begin
          if (rp_q != cnt_q) rp_q <= rp_q + 1'b1;
          scan_live_q <= (rp_q != cnt_q);
        end
      end else if (cmd_i.commit) begin
        if (full_drop) begin
          ovf_q <= 1'b1;
        end else begin
          bank_q <= ~bank_q;
          cnt_q <= wr_fin ? wp_q + 1'b1 : wp_q;
          if (cnt_q == '0) begin
            smin_q <= lo_q; smax_q <= hi_q;
          end else begin
            if (lo_q < smin_q) smin_q <= lo_q;
            if (hi_q > smax_q) smax_q <= hi_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i; idx_q <= index_i;
      lo_q <= (a_c < b_c) ? a_c : b_c;
      hi_q <= (a_c < b_c) ? b_c : a_c;
    end
    if (cmd_i.rd_issue) rd_q <= bank_q ? mem_b[rd_addr] : mem_a[rd_addr];
  end

  assign rd_valid = (32'(idx_q) < 32'(cnt_q)) && (32'(idx_q) < MAX_INTERVALS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      entry_valid_o    <= kind_q && rd_valid;
      entry_low_o      <= (kind_q && rd_valid) ? FW'(signed'(rd_q[2*W-1:W])) : '0;
      entry_high_o     <= (kind_q && rd_valid) ? FW'(signed'(rd_q[W-1:0])) : '0;
      interval_total_o <= siut_pkg::TotalWidth'(cnt_q);
      span_min_o       <= FW'(smin_q);
      span_max_o       <= FW'(smax_q);
      overflow_o       <= !kind_q && ovf_q;
    end
  end
endmodule

FILE: sv/siut_ctrl.sv
// Controller of the sorted interval union table.
// Depends on siut_pkg; drives the datapath by cmd_t, reads status_t.
module siut_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  siut_pkg::status_t status_i,
  output siut_pkg::cmd_t    cmd_o
);
  siut_pkg::state_e state_q, state_d;
  logic             ovalid_q;
  logic             busy;
  logic             fin;

  assign busy = (state_q != siut_pkg::ST_IDLE);
  assign in_ready_o = !busy && (!ovalid_q || out_ready_i);
  assign out_valid_o = ovalid_q;
  assign fin = (state_q == siut_pkg::ST_DONE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      siut_pkg::ST_IDLE:
        if (in_valid_i && in_ready_o)
          state_d = (kind_i == siut_pkg::KIND_READ) ? siut_pkg::ST_READ : siut_pkg::ST_SCAN;
      siut_pkg::ST_SCAN:  if (status_i.scan_done) state_d = siut_pkg::ST_WRITE;
      siut_pkg::ST_WRITE: state_d = siut_pkg::ST_DONE;
      siut_pkg::ST_READ:  state_d = siut_pkg::ST_DONE;
      siut_pkg::ST_DONE:  if (!ovalid_q || out_ready_i) state_d = siut_pkg::ST_IDLE;
      default:            state_d = siut_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      siut_pkg::ST_IDLE:  cmd_o.load = in_valid_i && in_ready_o;
      siut_pkg::ST_SCAN:  cmd_o.scan_step = 1'b1;
      siut_pkg::ST_WRITE: cmd_o.commit = 1'b1;
      siut_pkg::ST_READ:  cmd_o.rd_issue = 1'b1;
      siut_pkg::ST_DONE:  cmd_o.finish = !ovalid_q || out_ready_i;
      default:            cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= siut_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin && cmd_o.finish) ovalid_q <= 1'b1;
      else if (out_ready_i)    ovalid_q <= 1'b0;
    end
  end
endmodule

FILE: sv/sorted_interval_union_table_core.sv
// Top level of the sorted interval union table.
// Depends on siut_pkg, siut_ctrl and siut_datapath.
//
// channel | handshake            | payload
// in      | in_valid_i/in_ready_o| kind_i bound_a_i bound_b_i index_i
// out     | out_valid_o/out_ready_i | entry_* interval_total_o span_* overflow_o
//
// A read is taken, reads the table and forms the result. An add is taken,
// primes the table read, scans each stored interval in turn, writes back and
// forms the result; the scan takes one extra step when the new or merged
// interval is written ahead of a stored one.
// Reset clears the count and span; table contents are undefined until written.
// A result waits in the output register; a new item is taken once it drains.
module sorted_interval_union_table_core #(
  parameter int unsigned MAX_INTERVALS = siut_pkg::MaxIntervals,
  parameter int unsigned COORD_WIDTH   = siut_pkg::CoordWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] bound_a_i,
  input  logic [31:0] bound_b_i,
  input  logic [3:0]  index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] entry_low_o,
  output logic [31:0] entry_high_o,
  output logic        entry_valid_o,
  output logic [4:0]  interval_total_o,
  output logic [31:0] span_min_o,
  output logic [31:0] span_max_o,
  output logic        overflow_o
);
  siut_pkg::cmd_t    cmd;
  siut_pkg::status_t status;

  siut_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i,
    .out_valid_o, .out_ready_i, .status_i(status), .cmd_o(cmd)
  );

  siut_datapath #(.MAX_INTERVALS(MAX_INTERVALS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .kind_i, .bound_a_i, .bound_b_i, .index_i,
    .entry_low_o, .entry_high_o, .entry_valid_o, .interval_total_o,
    .span_min_o, .span_max_o, .overflow_o
  );

  // Hold off input while a scan or write-back is under way.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan_step || cmd.commit) |-> !in_ready_o) else $error("accept while busy");
  a_read_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_valid_o) |-> !overflow_o) else $error("read flagged overflow");
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(interval_total_o) <= MAX_INTERVALS)) else $error("count range");
  a_cmd_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd)) else $error("commands overlap");
endmodule
